// File: hw/rtl/psl_pkg.sv
// psl_pkg: shared types, widths and codes for the polygon splitter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package psl_pkg;

    // APB address width: five 32-bit registers at 4*i
    localparam int ADDR_W  = 5;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;        // difference of two coordinates
    localparam int MUL_W   = DIFF_W + 1;         // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CROSS_W = 2 * DIFF_W;         // exact cross product
    localparam int DEN_W   = CROSS_W + 1;        // difference of two cross products
    localparam int DVD_W   = CROSS_W + COORD_W;  // offset magnitude times |cp|
    localparam int QUO_W   = COORD_W + 1;
    localparam int REM_W   = DEN_W + 1;
    localparam int CNT_W   = 6;

    // register indexes
    localparam logic [2:0] REG_LINE_AX   = 3'd0;
    localparam logic [2:0] REG_LINE_AY   = 3'd1;
    localparam logic [2:0] REG_LINE_BX   = 3'd2;
    localparam logic [2:0] REG_LINE_BY   = 3'd3;
    localparam logic [2:0] REG_KEEP_SIDE = 3'd4;

    localparam logic [COORD_W-1:0] LINE_BX_RESET = 32'h0001_0000;

    // result targets
    localparam logic [1:0] TGT_KEEP  = 2'd0;
    localparam logic [1:0] TGT_OTHER = 2'd1;
    localparam logic [1:0] TGT_BOTH  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] line_ax;
        logic [COORD_W-1:0] line_ay;
        logic [COORD_W-1:0] line_bx;
        logic [COORD_W-1:0] line_by;
        logic               keep_side;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quo;
    } div_rsp_t;

endpackage

// File: hw/rtl/psl_cfg.sv
// psl_cfg: APB register file holding the split line and the kept side.
// Depends on psl_pkg.
`timescale 1ns / 1ps

module psl_cfg import psl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_ax   <= '0;
            cfg_reg.line_ay   <= '0;
            cfg_reg.line_bx   <= LINE_BX_RESET;
            cfg_reg.line_by   <= '0;
            cfg_reg.keep_side <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_LINE_AX:   cfg_reg.line_ax   <= pwdata;
                REG_LINE_AY:   cfg_reg.line_ay   <= pwdata;
                REG_LINE_BX:   cfg_reg.line_bx   <= pwdata;
                REG_LINE_BY:   cfg_reg.line_by   <= pwdata;
                REG_KEEP_SIDE: cfg_reg.keep_side <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_LINE_AX:   prdata = cfg_reg.line_ax;
            REG_LINE_AY:   prdata = cfg_reg.line_ay;
            REG_LINE_BX:   prdata = cfg_reg.line_bx;
            REG_LINE_BY:   prdata = cfg_reg.line_by;
            REG_KEEP_SIDE: prdata = {31'd0, cfg_reg.keep_side};
            default:       prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/psl_mul.sv
// psl_mul: shared signed multiplier with a registered product.
// Depends on psl_pkg.
`timescale 1ns / 1ps

module psl_mul import psl_pkg::*; (
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  mul_a,
    input  logic signed [MUL_W-1:0]  mul_b,
    output logic        [PROD_W-1:0] mul_prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // register every product; the sequencer picks it up in the following cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign mul_prod = prod_reg;

endmodule

// File: hw/rtl/psl_div.sv
// psl_div: restoring divider, one quotient bit per cycle, round half up.
// Depends on psl_pkg.
`timescale 1ns / 1ps

module psl_div import psl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    logic [REM_W-1:0]   rem_reg;
    logic [COORD_W-1:0] low_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [REM_W-1:0]   trial;
    logic               fits;
    logic               round_up;

    assign trial    = {rem_reg[REM_W-2:0], low_reg[COORD_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign round_up = {rem_reg[REM_W-2:0], 1'b0} >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                // load upper dividend bits; they are already below the divisor
                rem_reg  <= {2'b00, div_req.dividend[DVD_W-1:COORD_W]};
                low_reg  <= div_req.dividend[COORD_W-1:0];
                den_reg  <= div_req.divisor;
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(COORD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg != '0) begin
                // shift in one dividend bit, subtract when it fits
                rem_reg  <= fits ? trial - {1'b0, den_reg} : trial;
                low_reg  <= {low_reg[COORD_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
            end else if (busy_reg) begin
                // round to nearest, ties up
                quo_reg  <= quo_reg + QUO_W'(round_up);
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quo  = quo_reg;

endmodule

// File: hw/rtl/psl_seq.sv
// psl_seq: sequencer for side tests, edge crossings and result emission.
// Depends on psl_pkg; drives the shared multiplier and divider.
`timescale 1ns / 1ps

module psl_seq import psl_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [COORD_W-1:0]        s_vert_x,
    input  logic [COORD_W-1:0]        s_vert_y,
    input  logic                      s_closing,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [COORD_W-1:0]        m_out_x,
    output logic [COORD_W-1:0]        m_out_y,
    output logic [1:0]                m_target,
    output logic                      m_run_end,
    output logic signed [MUL_W-1:0]   mul_a,
    output logic signed [MUL_W-1:0]   mul_b,
    input  logic [PROD_W-1:0]         mul_prod,
    output div_req_t                  div_req,
    input  div_rsp_t                  div_rsp
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_XA    = 14'b00000000000010,
        S_XB    = 14'b00000000000100,
        S_XC    = 14'b00000000001000,
        S_PLAN  = 14'b00000000010000,
        S_EDGE  = 14'b00000000100000,
        S_ECHK  = 14'b00000001000000,
        S_L0    = 14'b00000010000000,
        S_L1    = 14'b00000100000000,
        S_L2    = 14'b00001000000000,
        S_L3    = 14'b00010000000000,
        S_LW    = 14'b00100000000000,
        S_EMITI = 14'b01000000000000,
        S_EMITV = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        PT_CUR   = 2'd0,
        PT_PREV  = 2'd1,
        PT_FIRST = 2'd2
    } pt_t;

    state_t state_reg, state_next;
    pt_t    pt_reg;

    logic [COORD_W-1:0] vx_reg, vy_reg;
    logic               closing_reg;
    logic [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic               first_side_reg, prev_side_reg, in_poly_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [CROSS_W-1:0] cross_cur_reg, cross_prev_reg, cross_first_reg;
    logic               side_reg, need2_reg, edge_reg;
    logic [COORD_W-1:0] ep_x_reg, ep_y_reg, eq_x_reg, eq_y_reg;
    logic [CROSS_W-1:0] cp_reg, cq_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [CROSS_W-1:0] an_reg;
    logic [DEN_W-1:0]   ad_reg;
    logic               cidx_reg, dneg_reg;
    logic [COORD_W-1:0] m_reg;
    logic [COORD_W-1:0] rx_reg, ry_reg;
    logic               m_valid_reg, m_run_end_reg;
    logic [COORD_W-1:0] m_out_x_reg, m_out_y_reg;
    logic [1:0]         m_target_reg;

    logic [COORD_W-1:0] px, py;
    logic [DIFF_W-1:0]  ux, uy, vxd, vyd;
    logic [CROSS_W-1:0] cross_w;
    logic               side_w, need1_w, out_free, emit_w;
    logic               den_zero, p_pick, q_pick, lerp_go;
    logic [CROSS_W-1:0] an_w;
    logic [DEN_W-1:0]   ad_w;
    logic [COORD_W-1:0] lp, lq;
    logic [DIFF_W-1:0]  d_w, dabs_w;
    logic [QUO_W-1:0]   qc_w;
    logic [COORD_W-1:0] coord_w;

    assign s_ready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_w   = out_free && ((state_reg == S_EMITI) || (state_reg == S_EMITV));

    // line direction and offset of the point under test
    always_comb begin
        case (pt_reg)
            PT_PREV:  begin px = prev_x_reg;  py = prev_y_reg;  end
            PT_FIRST: begin px = first_x_reg; py = first_y_reg; end
            default:  begin px = vx_reg;      py = vy_reg;      end
        endcase
    end

    assign ux  = {cfg.line_bx[COORD_W-1], cfg.line_bx} - {cfg.line_ax[COORD_W-1], cfg.line_ax};
    assign uy  = {cfg.line_by[COORD_W-1], cfg.line_by} - {cfg.line_ay[COORD_W-1], cfg.line_ay};
    assign vxd = {px[COORD_W-1], px} - {cfg.line_ax[COORD_W-1], cfg.line_ax};
    assign vyd = {py[COORD_W-1], py} - {cfg.line_ay[COORD_W-1], cfg.line_ay};
    assign cross_w = CROSS_W'(acc_reg - mul_prod);

    // side of the current vertex and whether the incoming edge crosses
    assign side_w  = !cross_cur_reg[CROSS_W-1] && (cross_cur_reg != '0);
    assign need1_w = in_poly_reg && (side_w != prev_side_reg);

    // crossing classification
    assign an_w     = cp_reg[CROSS_W-1] ? CROSS_W'(-cp_reg) : cp_reg;
    assign ad_w     = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : den_reg;
    assign den_zero = (den_reg == '0);
    assign p_pick   = !den_zero && (cp_reg != '0) && (cp_reg[CROSS_W-1] != den_reg[DEN_W-1]);
    assign q_pick   = ({1'b0, an_w} >= ad_w);
    assign lerp_go  = !den_zero && !p_pick && !q_pick;

    // per-coordinate offset and final point
    assign lp     = cidx_reg ? ep_y_reg : ep_x_reg;
    assign lq     = cidx_reg ? eq_y_reg : eq_x_reg;
    assign d_w    = {lq[COORD_W-1], lq} - {lp[COORD_W-1], lp};
    assign dabs_w = d_w[DIFF_W-1] ? DIFF_W'(-d_w) : d_w;
    assign qc_w   = (div_rsp.quo > {1'b0, m_reg}) ? {1'b0, m_reg} : div_rsp.quo;
    assign coord_w = dneg_reg ? lp - qc_w[COORD_W-1:0] : lp + qc_w[COORD_W-1:0];

    // multiplier operands per step
    always_comb begin
        case (state_reg)
            S_XA:    begin mul_a = {ux[DIFF_W-1], ux}; mul_b = {vyd[DIFF_W-1], vyd}; end
            S_XB:    begin mul_a = {uy[DIFF_W-1], uy}; mul_b = {vxd[DIFF_W-1], vxd}; end
            S_L1:    begin mul_a = {2'b00, m_reg}; mul_b = {1'b0, an_reg[DIFF_W-1:0]}; end
            S_L2:    begin mul_a = {2'b00, m_reg}; mul_b = {1'b0, an_reg[CROSS_W-1:DIFF_W]}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // divider launch: full product m*|cp| from its two halves
    assign div_req.start    = (state_reg == S_L3);
    assign div_req.dividend = DVD_W'({33'd0, acc_reg[DVD_W-DIFF_W-1:0]})
                            + {mul_prod[DVD_W-DIFF_W-1:0], {DIFF_W{1'b0}}};
    assign div_req.divisor  = ad_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_XA;
            S_XA:    state_next = S_XB;
            S_XB:    state_next = S_XC;
            S_XC:    state_next = (pt_reg == PT_FIRST) ? S_PLAN : S_XA;
            S_PLAN:  state_next = need1_w ? S_EDGE : S_EMITV;
            S_EDGE:  state_next = S_ECHK;
            S_ECHK:  state_next = lerp_go ? S_L0 : S_EMITI;
            S_L0:    state_next = S_L1;
            S_L1:    state_next = S_L2;
            S_L2:    state_next = S_L3;
            S_L3:    state_next = S_LW;
            S_LW:    if (div_rsp.done) state_next = cidx_reg ? S_EMITI : S_L0;
            S_EMITI: if (out_free) state_next = edge_reg ? S_IDLE : S_EMITV;
            S_EMITV: if (out_free) state_next = need2_reg ? S_EDGE : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            in_poly_reg    <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            first_side_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_side_reg  <= 1'b0;
            pt_reg         <= PT_CUR;
        end else begin
            state_reg <= state_next;
            // drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && !emit_w) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        vx_reg      <= s_vert_x;
                        vy_reg      <= s_vert_y;
                        closing_reg <= s_closing;
                        pt_reg      <= PT_CUR;
                    end
                end
                S_XB: acc_reg <= mul_prod;
                S_XC: begin
                    // store the cross product and advance to the next point
                    case (pt_reg)
                        PT_PREV:  begin cross_prev_reg  <= cross_w; pt_reg <= PT_FIRST; end
                        PT_FIRST: begin cross_first_reg <= cross_w; pt_reg <= PT_CUR;   end
                        default:  begin cross_cur_reg   <= cross_w; pt_reg <= PT_PREV;  end
                    endcase
                end
                S_PLAN: begin
                    side_reg  <= side_w;
                    need2_reg <= closing_reg && in_poly_reg && (side_w != first_side_reg);
                    edge_reg  <= 1'b0;
                    ep_x_reg  <= prev_x_reg;
                    ep_y_reg  <= prev_y_reg;
                    eq_x_reg  <= vx_reg;
                    eq_y_reg  <= vy_reg;
                    cp_reg    <= cross_prev_reg;
                    cq_reg    <= cross_cur_reg;
                end
                S_EDGE: den_reg <= {cp_reg[CROSS_W-1], cp_reg} - {cq_reg[CROSS_W-1], cq_reg};
                S_ECHK: begin
                    an_reg   <= an_w;
                    ad_reg   <= ad_w;
                    cidx_reg <= 1'b0;
                    if (p_pick) begin
                        rx_reg <= ep_x_reg;
                        ry_reg <= ep_y_reg;
                    end else begin
                        rx_reg <= eq_x_reg;
                        ry_reg <= eq_y_reg;
                    end
                end
                S_L0: begin
                    dneg_reg <= d_w[DIFF_W-1];
                    m_reg    <= dabs_w[COORD_W-1:0];
                end
                S_L2: acc_reg <= mul_prod;
                S_LW: begin
                    if (div_rsp.done) begin
                        if (cidx_reg) ry_reg <= coord_w;
                        else          rx_reg <= coord_w;
                        cidx_reg <= 1'b1;
                    end
                end
                S_EMITI: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_out_x_reg   <= rx_reg;
                        m_out_y_reg   <= ry_reg;
                        m_target_reg  <= TGT_BOTH;
                        m_run_end_reg <= edge_reg;
                    end
                end
                S_EMITV: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_out_x_reg   <= vx_reg;
                        m_out_y_reg   <= vy_reg;
                        m_target_reg  <= (side_reg == cfg.keep_side) ? TGT_KEEP : TGT_OTHER;
                        m_run_end_reg <= !need2_reg;
                        // advance polygon state
                        if (!in_poly_reg) begin
                            first_x_reg    <= vx_reg;
                            first_y_reg    <= vy_reg;
                            first_side_reg <= side_reg;
                        end
                        prev_x_reg    <= vx_reg;
                        prev_y_reg    <= vy_reg;
                        prev_side_reg <= side_reg;
                        in_poly_reg   <= !closing_reg;
                        // set up the closing edge back to the first vertex
                        edge_reg <= 1'b1;
                        ep_x_reg <= vx_reg;
                        ep_y_reg <= vy_reg;
                        eq_x_reg <= first_x_reg;
                        eq_y_reg <= first_y_reg;
                        cp_reg   <= cross_cur_reg;
                        cq_reg   <= cross_first_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_x   = m_out_x_reg;
    assign m_out_y   = m_out_y_reg;
    assign m_target  = m_target_reg;
    assign m_run_end = m_run_end_reg;

endmodule

// File: hw/rtl/polygon_split_by_line.sv
// polygon_split_by_line: top level of the streaming polygon splitter.
// Depends on psl_pkg, psl_cfg, psl_mul, psl_div and psl_seq.
`timescale 1ns / 1ps
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------
//  config  | in/out    | psel penable pwrite paddr pwdata prdata pready
//  vertex  | in        | s_valid s_ready s_vert_x s_vert_y s_closing
//  result  | out       | m_valid m_ready m_out_x m_out_y m_target m_run_end
//
// A vertex that no edge crosses makes six passes through the shared 34x34 multiplier
// (three cross products), then is planned and emitted. Each crossing either clamps
// the point to an edge end or works out two coordinates, each from products on the
// shared multiplier and a quotient from the one-bit divider.
// s_ready is high only while idle; a result waiting on m_ready stalls the
// sequencer at its next emission. Reset is synchronous on aresetn.

module polygon_split_by_line import psl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_vert_x,
    input  logic [COORD_W-1:0] s_vert_y,
    input  logic               s_closing,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COORD_W-1:0] m_out_x,
    output logic [COORD_W-1:0] m_out_y,
    output logic [1:0]         m_target,
    output logic               m_run_end
);

    cfg_t                     cfg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0]        mul_prod;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    psl_cfg u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    psl_mul u_mul (.aclk, .mul_a, .mul_b, .mul_prod);

    psl_div u_div (.aclk, .aresetn, .div_req, .div_rsp);

    psl_seq u_seq (
        .aclk, .aresetn, .cfg,
        .s_valid, .s_ready, .s_vert_x, .s_vert_y, .s_closing,
        .m_valid, .m_ready, .m_out_x, .m_out_y, .m_target, .m_run_end,
        .mul_a, .mul_b, .mul_prod, .div_req, .div_rsp
    );

endmodule

// File: hw/rtl/psl_checker.sv
// psl_checker: port-level assertions for polygon_split_by_line.
// Depends on psl_pkg; bound to the top level below.
`timescale 1ns / 1ps

module psl_checker import psl_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [ADDR_W-1:0]  paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               s_valid,
    input logic               s_ready,
    input logic [COORD_W-1:0] s_vert_x,
    input logic [COORD_W-1:0] s_vert_y,
    input logic               s_closing,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COORD_W-1:0] m_out_x,
    input logic [COORD_W-1:0] m_out_y,
    input logic [1:0]         m_target,
    input logic               m_run_end
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
                                && $stable(m_target) && $stable(m_run_end))
        else $error("stalled result changed");

    // one vertex at a time: an accepted transaction drops ready
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after accepting a vertex");

    // only the three target codes appear
    a_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_target != 2'd3)
        else $error("illegal target code");

    // no result is pending right after reset
    a_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind polygon_split_by_line psl_checker u_psl_checker (.*);

// File: sim/psl_checker.sv
// psl_scoreboard: watches the register port and both streams of the polygon splitter,
// predicts every emitted point and compares it with what the block delivers.
// Depends on psl_pkg for widths, register indexes and target codes.
`timescale 1ns / 1ps

module psl_scoreboard import psl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [COORD_W-1:0] s_vert_x,
    input  logic [COORD_W-1:0] s_vert_y,
    input  logic               s_closing,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [COORD_W-1:0] m_out_x,
    input  logic [COORD_W-1:0] m_out_y,
    input  logic [1:0]         m_target,
    input  logic               m_run_end,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [1:0]  target;
        logic        run_end;
    } point_t;

    point_t pending_points[$];

    // shadow of the line and kept side
    logic signed [31:0] ln_ax, ln_ay, ln_bx, ln_by;
    logic               kept;
    // polygon walk state
    logic signed [31:0] start_x, start_y, last_x, last_y;
    logic               start_side, last_side, mid_polygon;

    assign pending = pending_points.size();

    // exact cross product (B-A) x (P-A)
    function automatic logic signed [127:0] cross_at(logic signed [31:0] px,
                                                     logic signed [31:0] py);
        logic signed [127:0] ux, uy, vx, vy;
        ux = ln_bx; ux = ux - ln_ax;
        uy = ln_by; uy = uy - ln_ay;
        vx = px;    vx = vx - ln_ax;
        vy = py;    vy = vy - ln_ay;
        return ux * vy - uy * vx;
    endfunction

    function automatic logic side_at(logic signed [31:0] px, logic signed [31:0] py);
        return cross_at(px, py) > 0;
    endfunction

    // p + (q-p)*num/den, magnitude rounded half away from zero, clamped to |q-p|
    function automatic logic [31:0] blend(logic signed [31:0] p, logic signed [31:0] q,
                                          logic [127:0] num, logic [127:0] den);
        logic signed [127:0] d, base;
        logic [127:0] m, quo;
        d = q; d = d - p;
        base = p;
        m = (d < 0) ? -d : d;
        quo = (2 * (m * num) + den) / (2 * den);
        if (quo > m) quo = m;
        return (d < 0) ? 32'(base - $signed(quo)) : 32'(base + $signed(quo));
    endfunction

    // intersection of edge P->Q with the line, saturated into the edge
    task automatic cut_point(input logic signed [31:0] px, py, qx, qy,
                             output logic [31:0] rx, ry);
        logic signed [127:0] cp, den;
        logic [127:0] an, ad;
        cp = cross_at(px, py);
        den = cp - cross_at(qx, qy);
        an = (cp < 0) ? -cp : cp;
        ad = (den < 0) ? -den : den;
        if (den == 0 || an >= ad) begin
            rx = qx; ry = qy;
        end else if (cp != 0 && ((cp < 0) != (den < 0))) begin
            rx = px; ry = py;
        end else begin
            rx = blend(px, qx, an, ad);
            ry = blend(py, qy, an, ad);
        end
    endtask

    // cp beyond den with opposite signs must give P, so test that first
    task automatic cut_edge(input logic signed [31:0] px, py, qx, qy,
                            output logic [31:0] rx, ry);
        logic signed [127:0] cp, den;
        cp = cross_at(px, py);
        den = cp - cross_at(qx, qy);
        if (den != 0 && cp != 0 && ((cp < 0) != (den < 0))) begin
            rx = px; ry = py;
        end else begin
            cut_point(px, py, qx, qy, rx, ry);
        end
    endtask

    task automatic predict_vertex(input logic signed [31:0] vx, vy, input logic fin);
        point_t pt;
        logic s;
        int first_idx;
        first_idx = pending_points.size();
        s = side_at(vx, vy);
        if (!mid_polygon) begin
            start_x = vx; start_y = vy; start_side = s;
        end else if (s != last_side) begin
            cut_edge(last_x, last_y, vx, vy, pt.x, pt.y);
            pt.target = TGT_BOTH; pt.run_end = 1'b0;
            pending_points.insert(pending_points.size(), pt);
        end
        pt.x = vx; pt.y = vy; pt.run_end = 1'b0;
        pt.target = (s == kept) ? TGT_KEEP : TGT_OTHER;
        pending_points.insert(pending_points.size(), pt);
        if (fin) begin
            if (mid_polygon && s != start_side) begin
                cut_edge(vx, vy, start_x, start_y, pt.x, pt.y);
                pt.target = TGT_BOTH; pt.run_end = 1'b0;
                pending_points.insert(pending_points.size(), pt);
            end
            mid_polygon = 1'b0;
        end else begin
            mid_polygon = 1'b1;
        end
        last_x = vx; last_y = vy; last_side = s;
        pending_points[pending_points.size()-1].run_end = 1'b1;
    endtask

    always @(posedge aclk) begin
        point_t want;
        if (!aresetn) begin
            ln_ax <= '0; ln_ay <= '0; ln_bx <= LINE_BX_RESET; ln_by <= '0; kept <= 1'b0;
            start_x <= '0; start_y <= '0; start_side <= 1'b0;
            last_x <= '0; last_y <= '0; last_side <= 1'b0; mid_polygon <= 1'b0;
            pending_points.delete();
            errors <= 0;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LINE_AX:   ln_ax = pwdata;
                    REG_LINE_AY:   ln_ay = pwdata;
                    REG_LINE_BX:   ln_bx = pwdata;
                    REG_LINE_BY:   ln_by = pwdata;
                    REG_KEEP_SIDE: kept = pwdata[0];
                    default: ;
                endcase
            end
            // predict each accepted vertex transaction
            if (s_valid && s_ready)
                predict_vertex(s_vert_x, s_vert_y, s_closing);
            // compare each delivered point against the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_points.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected point x=%h y=%h target=%0d end=%b",
                                 m_out_x, m_out_y, m_target, m_run_end);
                    errors = errors + 1;
                end else begin
                    want = pending_points.pop_front();
                    if (want.x !== m_out_x || want.y !== m_out_y ||
                        want.target !== m_target || want.run_end !== m_run_end) begin
                        if (errors < 10)
                            $display("point mismatch: exp x=%h y=%h target=%0d end=%b, got x=%h y=%h target=%0d end=%b",
                                     want.x, want.y, want.target, want.run_end,
                                     m_out_x, m_out_y, m_target, m_run_end);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb_polygon_split_by_line.sv
// tb_polygon_split_by_line: drives vertex polygons and line settings into the splitter
// under random stalls; psl_scoreboard predicts and compares the emitted points.
// Depends on psl_pkg, psl_scoreboard and the polygon_split_by_line RTL.
`timescale 1ns / 1ps

module tb_polygon_split_by_line;
    import psl_pkg::*;

    localparam int LIMIT  = 5000;
    localparam int SETTLE = 250;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [COORD_W-1:0] s_vert_x = '0, s_vert_y = '0;
    logic               s_closing = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COORD_W-1:0] m_out_x, m_out_y;
    logic [1:0]         m_target;
    logic               m_run_end;
    int                 errors, pending;
    logic               jitter = 1'b1;
    int                 stall_left = 0;
    int                 quiet_cycles = 0;

    always #10 aclk = ~aclk;

    polygon_split_by_line DUT (.*);

    psl_scoreboard u_checker (.*);

    // result side: random stall bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (jitter && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            quiet_cycles <= 0;
        else if (quiet_cycles >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_line(input logic [31:0] ax, ay, bx, by, input logic keep);
        reg_write(REG_LINE_AX, ax);
        reg_write(REG_LINE_AY, ay);
        reg_write(REG_LINE_BX, bx);
        reg_write(REG_LINE_BY, by);
        reg_write(REG_KEEP_SIDE, {31'd0, keep});
    endtask

    // stop sending, then hold off until every predicted point is out and the block settled
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_vertex(input logic [31:0] x, y, input logic fin);
        if (jitter && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1; s_vert_x <= x; s_vert_y <= y; s_closing <= fin;
        do @(posedge aclk); while (!s_ready);
    endtask

    // mostly near the origin, sometimes anywhere in the full range
    function automatic logic [31:0] pick_coord(int span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 2 * span)) - span) <<< $urandom_range(0, 16);
    endfunction

    task automatic random_polygons(input int count, input int span);
        int n, len;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                send_vertex(pick_coord(span), pick_coord(span), k == len - 1);
                n++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset line is the x axis: single vertex, then a crossing triangle
        send_vertex(32'h0003_0000, 32'h0002_0000, 1'b1);
        send_vertex(32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
        send_vertex(32'h0000_0000, 32'h0001_0000, 1'b0);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 1'b1);
        // field extremes
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        // open a polygon above the axis, then move the line mid polygon
        send_vertex(32'h0000_0000, 32'h0001_0000, 1'b0);
        drain();
        set_line(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
        // lands on the new line with a stale side: zero denominator
        send_vertex(32'h0005_0000, 32'h0001_0000, 1'b0);
        send_vertex(32'h0002_0000, 32'h0004_0000, 1'b0);
        send_vertex(32'hFFFE_0000, 32'hFFFC_0000, 1'b1);
        drain();
        // degenerate line: A equals B
        set_line(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321, 1'b0);
        send_vertex(32'h0001_0000, 32'h0002_0000, 1'b0);
        send_vertex(32'hFFF0_0000, 32'h0010_0000, 1'b1);
        drain();
        // extreme line points
        set_line(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        drain();

        // random phases with fresh lines
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) jitter = 1'b0;
            if (ph == 4)
                set_line($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
            else
                set_line(pick_coord(64), pick_coord(64), pick_coord(64), pick_coord(64),
                         $urandom_range(0, 1));
            random_polygons(78, (ph % 2) ? 4096 : 64);
            drain();
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
